FILE: rtl/core/nps_pkg.sv
package nps_pkg;

    localparam int PAGE_BYTES = 2048;
    localparam int CNT_W      = 12;
    localparam int COL_W      = 11;
    localparam int ROW_W      = 17;
    localparam int STEP_N     = 8;
    localparam int STEP_IDX_W = 3;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    localparam logic [CNT_W-1:0] PAGE_SIZE = CNT_W'(PAGE_BYTES);

    // host request codes
    localparam logic [2:0] CMD_READ_START = 3'd0;
    localparam logic [2:0] CMD_READ_BYTE  = 3'd1;
    localparam logic [2:0] CMD_PROG_START = 3'd2;
    localparam logic [2:0] CMD_PROG_BYTE  = 3'd3;
    localparam logic [2:0] CMD_ERASE      = 3'd4;

    // bus cycle kinds
    localparam logic [2:0] KIND_CMD  = 3'd0;
    localparam logic [2:0] KIND_ADDR = 3'd1;
    localparam logic [2:0] KIND_WR   = 3'd2;
    localparam logic [2:0] KIND_RD   = 3'd3;
    localparam logic [2:0] KIND_WAIT = 3'd4;
    localparam logic [2:0] KIND_STAT = 3'd5;
    localparam logic [2:0] KIND_ERR  = 3'd6;

    // nand opcodes
    localparam logic [7:0] NAND_READ          = 8'h00;
    localparam logic [7:0] NAND_READ_CONFIRM  = 8'h30;
    localparam logic [7:0] NAND_PROG          = 8'h80;
    localparam logic [7:0] NAND_PROG_CONFIRM  = 8'h10;
    localparam logic [7:0] NAND_ERASE         = 8'h60;
    localparam logic [7:0] NAND_ERASE_CONFIRM = 8'hD0;
    localparam logic [7:0] NAND_STATUS        = 8'h70;
    localparam logic [7:0] ERASE_ROW_LOW_MASK = 8'hC0;

    // step masks for the start and erase sequences
    localparam logic [STEP_N-1:0] READ_START_MASK = 8'h7F;
    localparam logic [STEP_N-1:0] PROG_START_MASK = 8'h3F;
    localparam logic [STEP_N-1:0] ERASE_MASK      = 8'h7F;

    // step positions for byte requests
    localparam int BIT_WAIT  = 0;
    localparam int BIT_RD    = 1;
    localparam int BIT_WR    = 2;
    localparam int BIT_C10   = 3;
    localparam int BIT_WAIT2 = 4;
    localparam int BIT_C70   = 5;
    localparam int BIT_STAT  = 6;
    localparam int BIT_ERR   = 7;

    typedef enum logic [3:0] {
        MODE_IDLE = 4'b0001,
        MODE_READ = 4'b0010,
        MODE_PROG = 4'b0100,
        MODE_STAT = 4'b1000
    } mode_t;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_ERASE = 2'd1,
        OP_BYTE  = 2'd2
    } op_t;

    typedef struct packed {
        op_t               op;
        logic              is_read;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [CNT_W-1:0]  count;
        logic [7:0]        sample;
        logic [7:0]        dbyte;
        logic [STEP_N-1:0] mask;
    } desc_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

FILE: rtl/core/nand_page_command_sequencer.sv
// nand page command sequencer
// slave stream s_*: one host request per handshake; s_tuser carries the
// request code and the status-sample flag, s_tdata the address, length,
// block, write byte and sampled bus byte
// master stream m_*: one nand bus cycle per handshake, m_tuser the cycle
// kind, m_tlast set on the final bus cycle caused by a request
// a request is classified and its state updated in the cycle it is taken,
// then queued (four deep) for the cycle generator
// a request passes the queue, the current-request register and the output register
// throughput: one bus cycle per clock from the generator while m_tready is high;
// a request holds the generator until all its bus cycles are out; requests
// keep being taken while the queue has room, one per clock
// reset: mode idle, no bytes pending, queue and output empty
// when m_tready is low the output holds, the generator stops and requests
// are taken until the queue is full
module nand_page_command_sequencer
    import nps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // byte_address, length, block_number, data_byte, bus_sample
    input  logic [3:0]  s_tuser,   // cmd, status_sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // bus_byte, clamped_count, pass
    output logic [2:0]  m_tuser,   // cycle_kind
    output logic        m_tlast
);

    fifo_stat_t fifo_stat;
    logic       push;
    logic       pop;
    desc_t      push_desc;
    desc_t      head;

    nps_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .fifo_stat (fifo_stat),
        .push      (push),
        .push_desc (push_desc)
    );

    nps_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head      (head),
        .stat      (fifo_stat)
    );

    nps_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .fifo_stat (fifo_stat),
        .head      (head),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == KIND_ERR || m_tuser == KIND_STAT)) |-> m_tlast)
        else $error("error or status cycle not last");

    a_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == KIND_WR || m_tuser == KIND_RD || m_tuser == KIND_WAIT
            || m_tuser == KIND_STAT || m_tuser == KIND_ERR)) |-> (m_tdata[19:8] == '0))
        else $error("count on a data or status cycle");

    a_pass_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[20]) |-> (m_tuser == KIND_STAT && !m_tdata[0]))
        else $error("pass outside a passing status cycle");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !fifo_stat.full)
        else $error("queue overrun");

endmodule

FILE: rtl/core/nps_fifo.sv
module nps_fifo
    import nps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  desc_t      push_desc,
    input  logic       pop,
    output desc_t      head,
    output fifo_stat_t stat
);

    desc_t                 mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] cnt_reg, cnt_next;

    assign stat.full  = (cnt_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

FILE: rtl/core/nps_front.sv
module nps_front
    import nps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,
    input  logic [3:0]  s_tuser,
    input  fifo_stat_t  fifo_stat,
    output logic        push,
    output desc_t       push_desc
);

    mode_t            mode_reg, mode_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic             wait_reg, wait_next;

    logic [2:0]       cmd;
    logic             is_status;
    logic [27:0]      byte_address;
    logic [CNT_W-1:0] length;
    logic [10:0]      block_number;
    logic [7:0]       data_byte;
    logic [7:0]       bus_sample;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [CNT_W-1:0] room;
    logic [CNT_W-1:0] clamped;
    logic [CNT_W-1:0] left_dec;
    logic             has_left;

    assign cmd          = s_tuser[2:0];
    assign is_status    = s_tuser[3];
    assign byte_address = s_tdata[27:0];
    assign length       = s_tdata[39:28];
    assign block_number = s_tdata[50:40];
    assign data_byte    = s_tdata[58:51];
    assign bus_sample   = s_tdata[66:59];

    assign col      = byte_address[COL_W-1:0];
    assign row      = byte_address[27:COL_W];
    assign room     = ({1'b0, col} < PAGE_SIZE) ? PAGE_SIZE - {1'b0, col} : '0;
    assign clamped  = (length < room) ? length : room;
    assign has_left = (left_reg != '0);
    assign left_dec = has_left ? left_reg - 1'b1 : left_reg;

    assign s_tready = !fifo_stat.full;
    assign push     = s_tvalid && s_tready;

    always_comb
    begin
        mode_next         = mode_reg;
        left_next         = left_reg;
        wait_next         = wait_reg;
        push_desc.op      = OP_BYTE;
        push_desc.is_read = 1'b0;
        push_desc.col     = col;
        push_desc.row     = row;
        push_desc.count   = '0;
        push_desc.sample  = bus_sample;
        push_desc.dbyte   = data_byte;
        push_desc.mask    = '0;
        if (mode_reg == MODE_STAT && is_status)
        begin
            push_desc.mask[BIT_STAT] = 1'b1;
            mode_next                = MODE_IDLE;
            left_next                = '0;
        end
        else if (cmd == CMD_READ_START)
        begin
            push_desc.op      = OP_START;
            push_desc.is_read = 1'b1;
            push_desc.count   = clamped;
            push_desc.mask    = READ_START_MASK;
            mode_next         = MODE_READ;
            left_next         = clamped;
            wait_next         = 1'b1;
        end
        else if (cmd == CMD_PROG_START)
        begin
            push_desc.op    = OP_START;
            push_desc.count = clamped;
            push_desc.mask  = PROG_START_MASK;
            mode_next       = MODE_PROG;
            left_next       = clamped;
            wait_next       = 1'b0;
        end
        else if (cmd == CMD_ERASE)
        begin
            push_desc.op   = OP_ERASE;
            push_desc.row  = ROW_W'({block_number, 6'b0});
            push_desc.mask = ERASE_MASK;
            mode_next      = MODE_STAT;
            left_next      = '0;
            wait_next      = 1'b0;
        end
        else if (cmd == CMD_READ_BYTE && mode_reg == MODE_READ && (wait_reg || has_left))
        begin
            push_desc.mask[BIT_WAIT] = wait_reg;
            push_desc.mask[BIT_RD]   = has_left;
            wait_next                = 1'b0;
            left_next                = left_dec;
            if (left_dec == '0)
            begin
                mode_next = MODE_IDLE;
            end
        end
        else if (cmd == CMD_PROG_BYTE && mode_reg == MODE_PROG)
        begin
            push_desc.mask[BIT_WR] = has_left;
            left_next              = left_dec;
            if (left_dec == '0)
            begin
                push_desc.mask[BIT_C10]   = 1'b1;
                push_desc.mask[BIT_WAIT2] = 1'b1;
                push_desc.mask[BIT_C70]   = 1'b1;
                mode_next                 = MODE_STAT;
                if (is_status)
                begin
                    push_desc.mask[BIT_STAT] = 1'b1;
                    mode_next                = MODE_IDLE;
                end
            end
        end
        else
        begin
            push_desc.mask[BIT_ERR] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            left_reg <= '0;
            wait_reg <= 1'b0;
        end
        else if (push)
        begin
            mode_reg <= mode_next;
            left_reg <= left_next;
            wait_reg <= wait_next;
        end
    end

endmodule

FILE: rtl/core/nps_back.sv
module nps_back
    import nps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  fifo_stat_t  fifo_stat,
    input  desc_t       head,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);

    logic              cur_valid_reg;
    desc_t             cur_reg;
    logic [STEP_N-1:0] mask_reg, mask_next;
    logic              out_valid_reg;
    logic [7:0]        byte_reg, byte_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              pass_reg, pass_next;
    logic [2:0]        kind_reg, kind_next;
    logic              last_reg, last_next;

    logic [STEP_N-1:0]     sel;
    logic [STEP_IDX_W-1:0] idx;
    logic                  emit;
    logic                  done;

    assign sel       = mask_reg & (~mask_reg + 1'b1);
    assign mask_next = mask_reg & ~sel;
    assign emit      = cur_valid_reg && (!out_valid_reg || m_tready);
    assign done      = emit && (mask_next == '0);
    assign pop       = !fifo_stat.empty && (!cur_valid_reg || done);

    always_comb
    begin
        idx = '0;
        for (int i = 0; i < STEP_N; i++)
        begin
            if (sel[i])
            begin
                idx = STEP_IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        kind_next  = KIND_CMD;
        byte_next  = '0;
        count_next = '0;
        pass_next  = 1'b0;
        last_next  = (mask_next == '0);
        case (cur_reg.op)
            OP_START:
            begin
                count_next = cur_reg.count;
                kind_next  = KIND_ADDR;
                case (idx)
                    3'd0:
                    begin
                        kind_next = KIND_CMD;
                        byte_next = cur_reg.is_read ? NAND_READ : NAND_PROG;
                    end
                    3'd1: byte_next = cur_reg.col[7:0];
                    3'd2: byte_next = 8'(cur_reg.col[COL_W-1:8]);
                    3'd3: byte_next = cur_reg.row[7:0];
                    3'd4: byte_next = cur_reg.row[15:8];
                    3'd5: byte_next = 8'(cur_reg.row[ROW_W-1:16]);
                    default:
                    begin
                        kind_next = KIND_CMD;
                        byte_next = NAND_READ_CONFIRM;
                    end
                endcase
            end
            OP_ERASE:
            begin
                case (idx)
                    3'd0: byte_next = NAND_ERASE;
                    3'd1:
                    begin
                        kind_next = KIND_ADDR;
                        byte_next = cur_reg.row[7:0] & ERASE_ROW_LOW_MASK;
                    end
                    3'd2:
                    begin
                        kind_next = KIND_ADDR;
                        byte_next = cur_reg.row[15:8];
                    end
                    3'd3:
                    begin
                        kind_next = KIND_ADDR;
                        byte_next = 8'(cur_reg.row[16]);
                    end
                    3'd4: byte_next = NAND_ERASE_CONFIRM;
                    3'd5: kind_next = KIND_WAIT;
                    default: byte_next = NAND_STATUS;
                endcase
            end
            default:
            begin
                case (idx)
                    3'(BIT_WAIT):  kind_next = KIND_WAIT;
                    3'(BIT_RD):
                    begin
                        kind_next = KIND_RD;
                        byte_next = cur_reg.sample;
                    end
                    3'(BIT_WR):
                    begin
                        kind_next = KIND_WR;
                        byte_next = cur_reg.dbyte;
                    end
                    3'(BIT_C10):   byte_next = NAND_PROG_CONFIRM;
                    3'(BIT_WAIT2): kind_next = KIND_WAIT;
                    3'(BIT_C70):   byte_next = NAND_STATUS;
                    3'(BIT_STAT):
                    begin
                        kind_next = KIND_STAT;
                        byte_next = cur_reg.sample;
                        pass_next = !cur_reg.sample[0];
                    end
                    default:       kind_next = KIND_ERR;
                endcase
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            mask_reg      <= '0;
        end
        else
        begin
            if (pop)
            begin
                cur_valid_reg <= 1'b1;
                mask_reg      <= head.mask;
            end
            else if (done)
            begin
                cur_valid_reg <= 1'b0;
                mask_reg      <= '0;
            end
            else if (emit)
            begin
                mask_reg <= mask_next;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head;
        end
        if (emit)
        begin
            kind_reg  <= kind_next;
            byte_reg  <= byte_next;
            count_reg <= count_next;
            pass_reg  <= pass_next;
            last_reg  <= last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b0, pass_reg, count_reg, byte_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

endmodule
